// ===== rtl/nsd_pkg.sv =====
// ----------------------------------------------------------------------------
// nsd_pkg: shared types and constants
// Opcodes, item control struct and fixed widths for the nearest seed shader.
// ----------------------------------------------------------------------------
package nsd_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SHADE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic valid;
    logic shade;
  } ctrl_t;

  localparam int          INDEX_BITS  = 4;
  localparam int          SCALE_BITS  = 22;
  localparam int          ALPHA_BITS  = 8;
  localparam int          FRAC_SHIFT  = 20;
  localparam int          RAD_SHIFT   = 8;
  localparam logic [21:0] SCALE_RESET = 22'd23634;
  localparam logic [7:0]  ALPHA_MAX   = 8'd255;

endpackage

// ===== rtl/nsd_if.sv =====
// ----------------------------------------------------------------------------
// nsd_if: channel interfaces
// Valid/ready channels for input items and alpha results.
// ----------------------------------------------------------------------------
interface nsd_in_if #(
  parameter int COORD_BITS = 10
);
  logic                           valid;
  logic                           ready;
  nsd_pkg::opcode_t               opcode;
  logic [nsd_pkg::INDEX_BITS-1:0] seed_index;
  logic [COORD_BITS-1:0]          coord_x;
  logic [COORD_BITS-1:0]          coord_y;

  modport source (output valid, opcode, seed_index, coord_x, coord_y, input ready);
  modport sink (input valid, opcode, seed_index, coord_x, coord_y, output ready);
  modport monitor (input valid, ready, opcode, seed_index, coord_x, coord_y);
endinterface

interface nsd_out_if;
  logic                           valid;
  logic                           ready;
  logic [nsd_pkg::ALPHA_BITS-1:0] alpha;

  modport source (output valid, alpha, input ready);
  modport sink (input valid, alpha, output ready);
  modport monitor (input valid, ready, alpha);
endinterface

// ===== rtl/nsd_cell.sv =====
// ----------------------------------------------------------------------------
// nsd_cell: one seed cell of the distance chain
// Holds one seed point, takes seed writes addressed to it and folds its
// squared distance into the running minimum of each passing pixel.
// ----------------------------------------------------------------------------
module nsd_cell #(
  parameter int COORD_BITS = 10,
  parameter int CELL_ID    = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  nsd_pkg::ctrl_t                 in_ctrl,
  input  logic [nsd_pkg::INDEX_BITS-1:0] in_index,
  input  logic [COORD_BITS-1:0]          in_x,
  input  logic [COORD_BITS-1:0]          in_y,
  input  logic [2*COORD_BITS:0]          in_best,
  output nsd_pkg::ctrl_t                 out_ctrl,
  output logic [nsd_pkg::INDEX_BITS-1:0] out_index,
  output logic [COORD_BITS-1:0]          out_x,
  output logic [COORD_BITS-1:0]          out_y,
  output logic [2*COORD_BITS:0]          out_best
);

  localparam bit ADDRESSABLE = CELL_ID < (2 ** nsd_pkg::INDEX_BITS);
  localparam logic [nsd_pkg::INDEX_BITS-1:0] MY_ID = nsd_pkg::INDEX_BITS'(CELL_ID);

  logic [COORD_BITS-1:0]   seed_x;
  logic [COORD_BITS-1:0]   seed_y;
  logic [COORD_BITS-1:0]   dx;
  logic [COORD_BITS-1:0]   dy;
  logic [2*COORD_BITS-1:0] sq_x;
  logic [2*COORD_BITS-1:0] sq_y;
  logic [2*COORD_BITS:0]   d2;
  logic                    hit;

  assign dx   = (in_x >= seed_x) ? (in_x - seed_x) : (seed_x - in_x);
  assign dy   = (in_y >= seed_y) ? (in_y - seed_y) : (seed_y - in_y);
  assign sq_x = dx * dx;
  assign sq_y = dy * dy;
  assign d2   = {1'b0, sq_x} + {1'b0, sq_y};
  assign hit  = ADDRESSABLE && (in_index == MY_ID);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else if (en) begin
      out_ctrl <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_index <= in_index;
      out_x     <= in_x;
      out_y     <= in_y;
      out_best  <= (d2 < in_best) ? d2 : in_best;
      if (in_ctrl.valid && !in_ctrl.shade && hit) begin
        seed_x <= in_x;
        seed_y <= in_y;
      end
    end
  end

endmodule

// ===== rtl/nsd_sqrt_step.sv =====
// ----------------------------------------------------------------------------
// nsd_sqrt_step: one stage of the square root pipeline
// Produces one root bit per stage by trial subtraction on the remainder.
// ----------------------------------------------------------------------------
module nsd_sqrt_step #(
  parameter int ROOT_BITS = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  nsd_pkg::ctrl_t         in_ctrl,
  input  logic [ROOT_BITS+1:0]   in_rem,
  input  logic [ROOT_BITS-1:0]   in_root,
  input  logic [2*ROOT_BITS-1:0] in_rad,
  output nsd_pkg::ctrl_t         out_ctrl,
  output logic [ROOT_BITS+1:0]   out_rem,
  output logic [ROOT_BITS-1:0]   out_root,
  output logic [2*ROOT_BITS-1:0] out_rad
);

  logic [ROOT_BITS+2:0] rem_sh;
  logic [ROOT_BITS+2:0] trial;
  logic                 take;

  assign rem_sh = {in_rem[ROOT_BITS:0], in_rad[2*ROOT_BITS-1 -: 2]};
  assign trial  = {1'b0, in_root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else if (en) begin
      out_ctrl <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= take ? (ROOT_BITS+2)'(rem_sh - trial) : rem_sh[ROOT_BITS+1:0];
      out_root <= {in_root[ROOT_BITS-2:0], take};
      out_rad  <= {in_rad[2*ROOT_BITS-3:0], 2'b00};
    end
  end

endmodule

// ===== rtl/nsd_scale.sv =====
// ----------------------------------------------------------------------------
// nsd_scale: alpha scaling and output register
// Multiplies the root by the scale, then shifts, saturates and holds alpha.
// ----------------------------------------------------------------------------
module nsd_scale #(
  parameter int ROOT_BITS = 15
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  nsd_pkg::ctrl_t                 in_ctrl,
  input  logic [ROOT_BITS-1:0]           in_root,
  input  logic [nsd_pkg::SCALE_BITS-1:0] scale,
  output logic                           out_valid,
  output logic [nsd_pkg::ALPHA_BITS-1:0] out_alpha
);

  localparam int PROD_BITS = ROOT_BITS + nsd_pkg::SCALE_BITS;
  localparam int HIGH_BITS = PROD_BITS - nsd_pkg::FRAC_SHIFT;

  logic                 prod_valid;
  logic [PROD_BITS-1:0] prod;
  logic [HIGH_BITS-1:0] prod_high;

  assign prod_high = prod[PROD_BITS-1:nsd_pkg::FRAC_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      prod_valid <= in_ctrl.valid && in_ctrl.shade;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_BITS'(in_root) * PROD_BITS'(scale);
      if (prod_high > HIGH_BITS'(nsd_pkg::ALPHA_MAX)) begin
        out_alpha <= nsd_pkg::ALPHA_MAX;
      end else begin
        out_alpha <= prod_high[nsd_pkg::ALPHA_BITS-1:0];
      end
    end
  end

endmodule

// ===== rtl/nearest_seed_distance_shade.sv =====
// ----------------------------------------------------------------------------
// nearest_seed_distance_shade: Worley F1 shading, Euclidean metric
// Chain of seed cells, pipelined square root and alpha scaling.
// ----------------------------------------------------------------------------
// use: items arrive on in_ch; a write item (opcode write) loads one seed
// point into the cell named by seed_index and gives no result, a shade item
// gives one alpha on out_ch. cfg_we/cfg_wdata load the alpha scale register.
// every item walks NUM_SEEDS seed cells, then COORD_BITS+5 root stages, a
// multiply stage and the output register. one item is taken every cycle
// while no result waits stalled on out_ch; the rate is set by the cell
// chain, where each cell does one distance and one compare per cycle.
// write items travel down the chain too, so a seed write only affects
// pixels that follow it.
// reset clears all valid flags and sets the scale to its default; the
// seed points are undefined until written.
// when out_ch stalls with a result waiting, the whole pipeline holds and
// in_ch.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module nearest_seed_distance_shade #(
  parameter int NUM_SEEDS  = 16,
  parameter int COORD_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  nsd_in_if.sink                         in_ch,
  nsd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [nsd_pkg::SCALE_BITS-1:0] cfg_wdata
);

  localparam int ROOT_BITS = COORD_BITS + 5;
  localparam int D2_BITS   = 2 * COORD_BITS + 1;

  logic                           en;
  logic [nsd_pkg::SCALE_BITS-1:0] alpha_scale;

  nsd_pkg::ctrl_t                 cell_ctrl  [NUM_SEEDS+1];
  logic [nsd_pkg::INDEX_BITS-1:0] cell_index [NUM_SEEDS+1];
  logic [COORD_BITS-1:0]          cell_x     [NUM_SEEDS+1];
  logic [COORD_BITS-1:0]          cell_y     [NUM_SEEDS+1];
  logic [D2_BITS-1:0]             cell_best  [NUM_SEEDS+1];

  nsd_pkg::ctrl_t                 sq_ctrl [ROOT_BITS+1];
  logic [ROOT_BITS+1:0]           sq_rem  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0]           sq_root [ROOT_BITS+1];
  logic [2*ROOT_BITS-1:0]         sq_rad  [ROOT_BITS+1];

  assign en          = !(out_ch.valid && !out_ch.ready);
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_scale <= nsd_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      alpha_scale <= cfg_wdata;
    end
  end

  assign cell_ctrl[0].valid = in_ch.valid;
  assign cell_ctrl[0].shade = (in_ch.opcode == nsd_pkg::OP_SHADE);
  assign cell_index[0]      = in_ch.seed_index;
  assign cell_x[0]          = in_ch.coord_x;
  assign cell_y[0]          = in_ch.coord_y;
  assign cell_best[0]       = '1;

  for (genvar i = 0; i < NUM_SEEDS; i++) begin : g_cell
    nsd_cell #(
      .COORD_BITS(COORD_BITS),
      .CELL_ID   (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_ctrl  (cell_ctrl[i]),
      .in_index (cell_index[i]),
      .in_x     (cell_x[i]),
      .in_y     (cell_y[i]),
      .in_best  (cell_best[i]),
      .out_ctrl (cell_ctrl[i+1]),
      .out_index(cell_index[i+1]),
      .out_x    (cell_x[i+1]),
      .out_y    (cell_y[i+1]),
      .out_best (cell_best[i+1])
    );
  end

  // radicand is best << 8, padded to an even width
  assign sq_ctrl[0] = cell_ctrl[NUM_SEEDS];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = {1'b0, cell_best[NUM_SEEDS], {nsd_pkg::RAD_SHIFT{1'b0}}};

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    nsd_sqrt_step #(
      .ROOT_BITS(ROOT_BITS)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_ctrl (sq_ctrl[k]),
      .in_rem  (sq_rem[k]),
      .in_root (sq_root[k]),
      .in_rad  (sq_rad[k]),
      .out_ctrl(sq_ctrl[k+1]),
      .out_rem (sq_rem[k+1]),
      .out_root(sq_root[k+1]),
      .out_rad (sq_rad[k+1])
    );
  end

  nsd_scale #(
    .ROOT_BITS(ROOT_BITS)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_ctrl  (sq_ctrl[ROOT_BITS]),
    .in_root  (sq_root[ROOT_BITS]),
    .scale    (alpha_scale),
    .out_valid(out_ch.valid),
    .out_alpha(out_ch.alpha)
  );

endmodule

// ===== rtl/nsd_checker.sv =====
// ----------------------------------------------------------------------------
// nsd_checker: port level checks for the nearest seed shader
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module nsd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [nsd_pkg::ALPHA_BITS-1:0] out_alpha
);

  // a waiting result holds until its transfer
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_alpha))
    else $error("stalled result changed");

  // input only backs off while a result is stalled
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

  // reset empties the pipeline
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // nothing comes out early after reset
  assert property (@(posedge clk) $past(rst) && rst |=> !out_valid ##1 !out_valid)
    else $error("result too soon after reset");

endmodule

bind nearest_seed_distance_shade nsd_checker u_nsd_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_alpha(out_ch.alpha)
);
